### rtl/pbo_pkg.sv
// Package for the periodic bond orientation block: payload structs, the job
// record that moves down the angle pipeline, widths, register indexes and the
// CORDIC arctangent table. No dependencies.
`default_nettype none

package pbo_pkg;

    // Field and datapath widths
    localparam int POS_W       = 32;   // Q15.16 coordinate
    localparam int DIFF_W      = 33;   // raw bond difference
    localparam int FOLD_W      = 34;   // d, d+L, d-L and their magnitudes
    localparam int CW          = 44;   // CORDIC x/y word, holds gain and sign
    localparam int ZW          = 33;   // Q30 angle accumulator, signed
    localparam int ANGLE_W     = 18;   // Q2.16 result angle
    localparam int BEADS_W     = 13;
    localparam int BOX_W       = 31;
    localparam int BEAD_IDX_W  = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Normalization brings the larger component into [2^40, 2^41)
    localparam int NORM_MSB         = 40;
    localparam int NORM_STAGES      = 6;
    localparam int NORM_FIRST_SHIFT = 32;

    // Filament length limits
    localparam logic [BEADS_W-1:0] BEADS_MIN = 13'd2;
    localparam logic [BEADS_W-1:0] BEADS_MAX = 13'd4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BEADS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd2;

    // Angle constants
    localparam logic [ZW-1:0]      HALF_PI_Q30 = 33'd1686629713;
    localparam logic [ANGLE_W-1:0] PI_Q16      = 18'd205887;
    localparam int                 Q_SHIFT     = 14;      // Q30 to Q16
    localparam logic [ZW-1:0]      ROUND_HALF  = 33'd8192;

    // atan(2^-i) in Q30, rounded to nearest
    localparam int ATAN_W     = 30;
    localparam int ATAN_DEPTH = 24;
    localparam logic [ATAN_W-1:0] ATAN_Q30 [ATAN_DEPTH] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } t_in;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               filament_end;
        logic               last;
    } t_out;

    typedef struct packed {
        logic filament_end;
        logic last;
    } t_tag;

    // One angle computation in flight
    typedef struct packed {
        logic                special;     // dy == 0: angle fixed, CORDIC ignored
        logic                special_pi;  // fixed angle is pi
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        t_tag                tag;
    } t_job;

endpackage

`default_nettype wire

### rtl/pbo_front.sv
// Front end: configuration registers, bead history, bond differences,
// minimum-image folding and quadrant mapping into a CORDIC job.
// Depends on pbo_pkg.
`default_nettype none

module pbo_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [pbo_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pbo_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    input  pbo_pkg::t_in                    i_in_data,
    output logic                            o_in_ready,
    input  logic                            i_en,
    output logic                            o_valid,
    output pbo_pkg::t_job                   o_job
);
    import pbo_pkg::*;

    // magnitude of a folded candidate
    function automatic logic [FOLD_W-1:0] mag(input logic signed [FOLD_W-1:0] v);
        mag = v[FOLD_W-1] ? FOLD_W'(-v) : v;
    endfunction

    // minimum image: smallest magnitude of d, d+L, d-L; a tie goes to the later one
    function automatic logic signed [FOLD_W-1:0] pick(
        input logic signed [FOLD_W-1:0] d,
        input logic signed [FOLD_W-1:0] d1,
        input logic signed [FOLD_W-1:0] d2,
        input logic [FOLD_W-1:0]        a,
        input logic [FOLD_W-1:0]        a1,
        input logic [FOLD_W-1:0]        a2
    );
        if (a < a1 && a < a2) begin
            pick = d;
        end else if (a1 < a2) begin
            pick = d1;
        end else begin
            pick = d2;
        end
    endfunction

    // configuration and bead history
    logic [BEADS_W-1:0]       r_beads;
    logic [BOX_W-1:0]         r_box_x;
    logic [BOX_W-1:0]         r_box_y;
    logic signed [POS_W-1:0]  r_prev_x [2];
    logic signed [POS_W-1:0]  r_prev_y [2];
    logic [BEAD_IDX_W-1:0]    r_bead;

    // second job of a last bead, queued at the transfer and issued once the pipeline is enabled
    logic                     r_pend_valid;
    logic signed [DIFF_W-1:0] r_pend_dx;
    logic signed [DIFF_W-1:0] r_pend_dy;

    // pipeline stages
    logic                     r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    t_tag                     r1_tag, r2_tag, r3_tag, r4_tag;
    logic signed [DIFF_W-1:0] r1_dx, r1_dy;
    logic signed [FOLD_W-1:0] r2_dx [3];
    logic signed [FOLD_W-1:0] r2_dy [3];
    logic signed [FOLD_W-1:0] r3_dx [3];
    logic signed [FOLD_W-1:0] r3_dy [3];
    logic [FOLD_W-1:0]        r3_ax [3];
    logic [FOLD_W-1:0]        r3_ay [3];
    logic signed [FOLD_W-1:0] r4_fx, r4_fy;
    t_job                     r5_job;

    logic signed [POS_W-1:0]  w_pos_x, w_pos_y;
    logic [BEADS_W-1:0]       w_eff;
    logic [BEADS_W-1:0]       w_last_idx;
    logic                     w_is_last;
    logic                     w_first;
    logic                     w_accept;
    logic signed [DIFF_W-1:0] w_d0_x, w_d0_y, w_d1_x, w_d1_y;

    logic                     n1_valid;
    t_tag                     n1_tag;
    logic signed [DIFF_W-1:0] n1_dx, n1_dy;
    logic signed [FOLD_W-1:0] w_negx, w_negy;
    logic                     w_fx_pos, w_fy_pos;
    t_job                     n5_job;

    assign w_pos_x    = i_in_data.pos_x;
    assign w_pos_y    = i_in_data.pos_y;
    assign o_in_ready = i_en & ~r_pend_valid;
    assign w_accept   = i_in_valid & o_in_ready;

    // effective filament length and position of this bead
    assign w_eff      = (r_beads < BEADS_MIN) ? BEADS_MIN :
                        (r_beads > BEADS_MAX) ? BEADS_MAX : r_beads;
    assign w_last_idx = w_eff - BEADS_W'(1);
    assign w_is_last  = {1'b0, r_bead} >= w_last_idx;
    assign w_first    = (r_bead == '0);

    // backward difference to the newest and to the second newest bead
    assign w_d0_x = DIFF_W'(w_pos_x) - DIFF_W'(r_prev_x[0]);
    assign w_d0_y = DIFF_W'(w_pos_y) - DIFF_W'(r_prev_y[0]);
    assign w_d1_x = DIFF_W'(w_pos_x) - DIFF_W'(r_prev_x[1]);
    assign w_d1_y = DIFF_W'(w_pos_y) - DIFF_W'(r_prev_y[1]);

    // job entering the pipeline this cycle
    always_comb begin
        n1_valid = 1'b0;
        n1_tag   = '{filament_end: 1'b0, last: 1'b1};
        n1_dx    = w_d1_x;
        n1_dy    = w_d1_y;
        if (r_pend_valid) begin
            n1_valid = 1'b1;
            n1_tag   = '{filament_end: 1'b1, last: 1'b1};
            n1_dx    = r_pend_dx;
            n1_dy    = r_pend_dy;
        end else if (w_accept && !w_first) begin
            n1_valid = 1'b1;
            n1_tag   = '{filament_end: 1'b0, last: ~w_is_last};
            if (r_bead == BEAD_IDX_W'(1)) begin
                n1_dx = w_d0_x;
                n1_dy = w_d0_y;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beads <= BEADS_MIN;
            r_box_x <= BOX_W'(65536);
            r_box_y <= BOX_W'(65536);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BEADS: r_beads <= i_cfg_data[BEADS_W-1:0];
                CFG_BOX_X: r_box_x <= i_cfg_data[BOX_W-1:0];
                CFG_BOX_Y: r_box_y <= i_cfg_data[BOX_W-1:0];
                default:   ;
            endcase
        end
    end

    // bead history, counter and pending second job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x[0]  <= '0;
            r_prev_x[1]  <= '0;
            r_prev_y[0]  <= '0;
            r_prev_y[1]  <= '0;
            r_bead       <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_en) begin
            if (r_pend_valid) begin
                r_pend_valid <= 1'b0;
            end else if (w_accept) begin
                r_prev_x[1] <= r_prev_x[0];
                r_prev_y[1] <= r_prev_y[0];
                r_prev_x[0] <= w_pos_x;
                r_prev_y[0] <= w_pos_y;
                if (w_first) begin
                    r_bead <= BEAD_IDX_W'(1);
                end else if (w_is_last) begin
                    r_bead       <= '0;
                    r_pend_valid <= 1'b1;
                end else begin
                    r_bead <= r_bead + BEAD_IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && !r_pend_valid) begin
            r_pend_dx <= w_d0_x;
            r_pend_dy <= w_d0_y;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= n1_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    // quadrant map: both components made non-negative, a quarter turn in z for the rotated cases
    assign w_negx   = -r4_fx;
    assign w_negy   = -r4_fy;
    assign w_fx_pos = ~r4_fx[FOLD_W-1] && (r4_fx != '0);
    assign w_fy_pos = ~r4_fy[FOLD_W-1] && (r4_fy != '0);

    always_comb begin
        n5_job            = '0;
        n5_job.tag        = r4_tag;
        n5_job.special    = (r4_fy == '0);
        n5_job.special_pi = r4_fx[FOLD_W-1];
        if (w_fy_pos) begin
            if (r4_fx[FOLD_W-1]) begin
                n5_job.x = CW'(r4_fy);
                n5_job.y = CW'(w_negx);
                n5_job.z = HALF_PI_Q30;
            end else begin
                n5_job.x = CW'(r4_fx);
                n5_job.y = CW'(r4_fy);
            end
        end else begin
            if (w_fx_pos) begin
                n5_job.x = CW'(w_negy);
                n5_job.y = CW'(r4_fx);
                n5_job.z = HALF_PI_Q30;
            end else begin
                n5_job.x = CW'(w_negx);
                n5_job.y = CW'(w_negy);
            end
        end
    end

    // datapath: difference, image candidates, magnitudes, pick, map
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx  <= n1_dx;
            r1_dy  <= n1_dy;
            r1_tag <= n1_tag;

            r2_dx[0] <= FOLD_W'(r1_dx);
            r2_dx[1] <= FOLD_W'(r1_dx) + FOLD_W'(r_box_x);
            r2_dx[2] <= FOLD_W'(r1_dx) - FOLD_W'(r_box_x);
            r2_dy[0] <= FOLD_W'(r1_dy);
            r2_dy[1] <= FOLD_W'(r1_dy) + FOLD_W'(r_box_y);
            r2_dy[2] <= FOLD_W'(r1_dy) - FOLD_W'(r_box_y);
            r2_tag   <= r1_tag;

            for (int k = 0; k < 3; k++) begin
                r3_dx[k] <= r2_dx[k];
                r3_dy[k] <= r2_dy[k];
                r3_ax[k] <= mag(r2_dx[k]);
                r3_ay[k] <= mag(r2_dy[k]);
            end
            r3_tag <= r2_tag;

            r4_fx  <= pick(r3_dx[0], r3_dx[1], r3_dx[2], r3_ax[0], r3_ax[1], r3_ax[2]);
            r4_fy  <= pick(r3_dy[0], r3_dy[1], r3_dy[2], r3_ay[0], r3_ay[1], r3_ay[2]);
            r4_tag <= r3_tag;

            r5_job <= n5_job;
        end
    end

    assign o_valid = r5_valid;
    assign o_job   = r5_job;

`ifndef SYNTHESIS
    a_last_bead_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_first && w_is_last) |=> (r_pend_valid && r_bead == '0))
        else $error("last bead did not queue its second job");
    a_pend_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && i_en) |=> !r_pend_valid)
        else $error("second job issued more than once");
`endif

endmodule

`default_nettype wire

### rtl/pbo_norm_cell.sv
// One normalization cell: shifts the job left by a fixed amount when the
// larger component stays below 2^41 after the shift. Depends on pbo_pkg.
`default_nettype none

module pbo_norm_cell #(
    parameter int SHIFT = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  pbo_pkg::t_job  i_job,
    output logic           o_valid,
    output pbo_pkg::t_job  o_job
);
    import pbo_pkg::*;

    logic r_valid;
    t_job r_job;
    t_job n_job;
    logic w_fits;

    // top SHIFT bits of the 41-bit magnitude window are clear in both
    assign w_fits = ((i_job.x[NORM_MSB -: SHIFT] | i_job.y[NORM_MSB -: SHIFT]) == '0);

    always_comb begin
        n_job = i_job;
        if (w_fits) begin
            n_job.x = i_job.x << SHIFT;
            n_job.y = i_job.y << SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_job <= n_job;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;

endmodule

`default_nettype wire

### rtl/pbo_cordic_cell.sv
// One CORDIC vectoring iteration, registered: rotates toward the x axis and
// accumulates the Q30 arctangent. Depends on pbo_pkg.
`default_nettype none

module pbo_cordic_cell #(
    parameter int ITER = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  pbo_pkg::t_job  i_job,
    output logic           o_valid,
    output pbo_pkg::t_job  o_job
);
    import pbo_pkg::*;

    logic                 r_valid;
    t_job                 r_job;
    t_job                 n_job;
    logic signed [CW-1:0] w_x, w_y, w_xs, w_ys;
    logic signed [ZW-1:0] w_z;
    logic [ZW-1:0]        w_step;

    assign w_x    = i_job.x;
    assign w_y    = i_job.y;
    assign w_z    = i_job.z;
    assign w_xs   = w_x >>> ITER;
    assign w_ys   = w_y >>> ITER;
    assign w_step = ZW'(ATAN_Q30[ITER]);

    // rotate by -atan(2^-i) while y is non-negative, else by +atan(2^-i)
    always_comb begin
        n_job = i_job;
        if (!w_y[CW-1]) begin
            n_job.x = w_x + w_ys;
            n_job.y = w_y - w_xs;
            n_job.z = w_z + w_step;
        end else begin
            n_job.x = w_x - w_ys;
            n_job.y = w_y + w_xs;
            n_job.z = w_z - w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_job <= n_job;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;

endmodule

`default_nettype wire

### rtl/pbo_out_buf.sv
// Result stage: rounds the Q30 angle to Q16, applies the fixed angles, and
// holds results in an output register backed by one skid entry.
// Depends on pbo_pkg.
`default_nettype none

module pbo_out_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  pbo_pkg::t_job  i_job,
    output logic           o_en,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pbo_pkg::t_out  o_out_data
);
    import pbo_pkg::*;

    localparam int T_W = ZW - Q_SHIFT;

    logic                 r_out_valid;
    t_out                 r_out;
    logic                 r_skid_valid;
    t_out                 r_skid;

    logic signed [ZW-1:0] w_z;
    logic [ZW-1:0]        w_sum;
    logic [T_W-1:0]       w_t;
    t_out                 w_res;
    logic                 w_take;
    logic                 w_push;

    // round half up to Q16, clamp to [0, pi]
    assign w_z   = i_job.z;
    assign w_sum = ZW'(w_z[ZW-2:0]) + ROUND_HALF;
    assign w_t   = w_sum[ZW-1:Q_SHIFT];

    always_comb begin
        w_res.filament_end = i_job.tag.filament_end;
        w_res.last         = i_job.tag.last;
        if (i_job.special) begin
            w_res.angle = i_job.special_pi ? PI_Q16 : '0;
        end else if (w_z[ZW-1]) begin
            w_res.angle = '0;
        end else if (w_t > T_W'(PI_Q16)) begin
            w_res.angle = PI_Q16;
        end else begin
            w_res.angle = w_t[ANGLE_W-1:0];
        end
    end

    // pipeline advances while the skid entry is free
    assign o_en   = ~r_skid_valid;
    assign w_take = r_out_valid & i_out_ready;
    assign w_push = o_en & i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.angle <= PI_Q16))
        else $error("angle above pi");
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.filament_end) |-> r_out.last)
        else $error("filament end result not flagged last");
`endif

endmodule

`default_nettype wire

### rtl/periodic_bond_orientation.sv
// Periodic bond orientation: takes one bead position per transfer and returns
// the headless bond angle of each bead in [0, pi], Q2.16, one bead per cycle
// while the output is not stalled (the last bead of a filament holds the input
// while its second job issues, since it gives two results). An input transfer
// reaches output valid through five front-end stages (difference, image
// candidates, magnitudes, image pick, quadrant map), six normalization cells,
// one cell per CORDIC iteration, and the output register; a bead's first
// result leaves with the transfer of the following bead. A full output
// register plus one skid entry stall the whole chain together.
// Depends on pbo_pkg and the pbo_* modules.
`default_nettype none

module periodic_bond_orientation #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pbo_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pbo_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pbo_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pbo_pkg::t_out                   o_out_data
);
    import pbo_pkg::*;

    logic w_en;
    logic w_nvalid [NORM_STAGES+1];
    t_job w_njob   [NORM_STAGES+1];
    logic w_cvalid [CORDIC_ITERATIONS+1];
    t_job w_cjob   [CORDIC_ITERATIONS+1];

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    pbo_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .i_en        (w_en),
        .o_valid     (w_nvalid[0]),
        .o_job       (w_njob[0])
    );

    // normalization chain: shifts of 32, 16, 8, 4, 2, 1
    for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
        pbo_norm_cell #(
            .SHIFT (NORM_FIRST_SHIFT >> k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_nvalid[k]),
            .i_job   (w_njob[k]),
            .o_valid (w_nvalid[k+1]),
            .o_job   (w_njob[k+1])
        );
    end

    assign w_cvalid[0] = w_nvalid[NORM_STAGES];
    assign w_cjob[0]   = w_njob[NORM_STAGES];

    // CORDIC chain, one iteration per cell
    for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cordic
        pbo_cordic_cell #(
            .ITER (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cvalid[i]),
            .i_job   (w_cjob[i]),
            .o_valid (w_cvalid[i+1]),
            .o_job   (w_cjob[i+1])
        );
    end

    pbo_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_cvalid[CORDIC_ITERATIONS]),
        .i_job       (w_cjob[CORDIC_ITERATIONS]),
        .o_en        (w_en),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
